>>> hdl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active
`define SLE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("line editor assertion failed");

// Implication form: antecedent |-> consequent
`define SLE_ASSERT_IMP(lbl, ante, cons) \
  `SLE_ASSERT(lbl, (ante) |-> (cons))

`endif

>>> hdl/sle_pkg.sv
// Package: result codes, scancode constants, key tables and shared types
package sle_pkg;

  localparam int LineCap = 32;

  // Result kinds
  localparam logic [1:0] KindEcho = 2'd0;
  localparam logic [1:0] KindLine = 2'd1;
  localparam logic [1:0] KindEnd  = 2'd2;

  // Scancodes
  localparam logic [7:0] ScPrefix   = 8'hE0;
  localparam logic [7:0] ScUp       = 8'h48;
  localparam logic [7:0] ScDown     = 8'h50;
  localparam logic [7:0] ScLShift   = 8'h2A;
  localparam logic [7:0] ScRShift   = 8'h36;
  localparam logic [7:0] ScLShiftUp = 8'hAA;
  localparam logic [7:0] ScRShiftUp = 8'hB6;
  localparam logic [7:0] ScCaps     = 8'h3A;
  localparam logic [7:0] ScTab      = 8'h0F;
  localparam logic [7:0] KeyCount   = 8'd58;

  localparam logic [6:0] ChBackspace = 7'h08;
  localparam logic [6:0] ChNewline   = 7'h0A;

  localparam logic [6:0] PlainKeys [58] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B,
    7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C,
    7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C,
    7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam logic [6:0] ShiftKeys [58] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B,
    7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C,
    7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C,
    7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  // One result item without its last flag
  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] char_code;
    logic [4:0] line_length;
  } res_t;

  // Control from the sequencer to the output stage
  typedef struct packed {
    logic push;
    logic close;
  } ost_ctl_t;

  // Key table lookup; code must be below KeyCount
  function automatic logic [6:0] key_char(input logic [7:0] code, input logic shifted);
    logic [6:0] c;
    c = shifted ? ShiftKeys[code[5:0]] : PlainKeys[code[5:0]];
    return c;
  endfunction

endpackage

>>> hdl/sle_in_if.sv
// Scancode input channel
interface sle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scancode;
  modport source (output valid, output scancode, input ready);
  modport sink   (input valid, input scancode, output ready);
endinterface

>>> hdl/sle_res_if.sv
// Result output channel
interface sle_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] char_code;
  logic [4:0] line_length;
  logic       last;
  modport source (output valid, output kind, output char_code, output line_length,
                  output last, input ready);
  modport sink   (input valid, input kind, input char_code, input line_length,
                  input last, output ready);
endinterface

>>> hdl/scancode_line_editor_with_history_unit.sv
// Top level: scancode line editor with line and history memories
//
//   channel   dir  handshake      payload
//   in_i      in   valid/ready    scancode
//   res_o     out  valid/ready    kind, char_code, line_length, last
//   cfg       in   cfg_we_i       cfg_data_i (line_limit)
//
// An item runs through PRE, DECODE and DONE; a recall adds ERASE and LOAD, and a
// finish adds FIN_CH and FIN_END. Results stream at one per cycle, unless the output
// stalls, from the single read port of the line or history memory.
// Reset clears flags, counters and the output stage; memories are not cleared.
// A stalled output holds the sequencer; input is taken only between items.
module scancode_line_editor_with_history_unit #(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sle_in_if.sink     in_i,
  sle_res_if.source  res_o,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_data_i
);
  import sle_pkg::*;

  localparam int SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int UW = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRE, ST_FIN_CH, ST_FIN_END, ST_DECODE, ST_ERASE, ST_LOAD, ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic [7:0] sc_q, sc_d;
  logic       handled_q, handled_d, load_q, load_d;
  logic       shift_q, shift_d, caps_q, caps_d, prefix_q, prefix_d;
  logic [4:0] fill_q, fill_d, idx_q, idx_d, ldn_q, ldn_d;
  logic [SW-1:0] next_q, next_d, rslot_q, rslot_d;
  logic [UW-1:0] used_q, used_d, off_q, off_d;
  logic [5:0] limit_q;
  logic [4:0] maxc;

  logic [6:0] line_mem [LineCap];
  logic [6:0] hist_mem [HISTORY_DEPTH*LineCap];
  logic [4:0] hlen_mem [HISTORY_DEPTH];
  logic [6:0] line_rd_q, hist_rd_q;

  logic       lwe, hwe, hlwe;
  logic [4:0] lwa;
  logic [6:0] lwd, key;
  logic [UW:0] slot_sum;

  ost_ctl_t ctl;
  res_t     pd;
  logic     can_push, closed;

  // clamp line_limit to [2, LineCap], then one less
  always_comb begin
    if (limit_q < 6'd2) maxc = 5'd1;
    else if (limit_q > 6'(LineCap)) maxc = 5'(LineCap - 1);
    else maxc = 5'(limit_q - 6'd1);
  end

  assign key       = key_char(sc_q, shift_q ^ caps_q);
  assign in_i.ready = (state_q == ST_IDLE);

  // sequencer next-state logic
  always_comb begin
    state_d = state_q; sc_d = sc_q; handled_d = handled_q; load_d = load_q;
    shift_d = shift_q; caps_d = caps_q; prefix_d = prefix_q;
    fill_d = fill_q; idx_d = idx_q; ldn_d = ldn_q;
    next_d = next_q; rslot_d = rslot_q; used_d = used_q; off_d = off_q;
    ctl = '0; pd = '0; slot_sum = '0;
    lwe = 1'b0; lwa = fill_q; lwd = key; hwe = 1'b0; hlwe = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          sc_d = in_i.scancode; handled_d = 1'b0; state_d = ST_PRE;
        end
      end
      ST_PRE: begin
        if (fill_q >= maxc) begin
          idx_d = '0; state_d = ST_FIN_CH;
        end else begin
          state_d = handled_q ? ST_DONE : ST_DECODE;
        end
      end
      ST_FIN_CH: begin
        if (idx_q == fill_q) state_d = ST_FIN_END;
        else if (can_push) begin
          ctl.push = 1'b1; pd = '{KindLine, line_rd_q, 5'd0};
          hwe = 1'b1; idx_d = idx_q + 5'd1;
        end
      end
      ST_FIN_END: begin
        if (can_push) begin
          ctl.push = 1'b1; pd = '{KindEnd, 7'd0, fill_q};
          if (fill_q != '0) begin
            hlwe = 1'b1;
            next_d = (next_q == SW'(HISTORY_DEPTH - 1)) ? '0 : next_q + 1'b1;
            if (used_q != UW'(HISTORY_DEPTH)) used_d = used_q + 1'b1;
          end
          shift_d = 1'b0; caps_d = 1'b0; prefix_d = 1'b0;
          fill_d = '0; off_d = '0;
          state_d = handled_q ? ST_DONE : ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_DONE;
        if (sc_q == ScPrefix) prefix_d = 1'b1;
        else if (prefix_q) begin
          prefix_d = 1'b0;
          if (sc_q == ScUp && off_q < used_q) begin
            off_d = off_q + 1'b1; load_d = 1'b1; state_d = ST_ERASE;
          end else if (sc_q == ScDown && off_q != '0) begin
            off_d = off_q - 1'b1; load_d = (off_q != UW'(1)); state_d = ST_ERASE;
          end
          slot_sum = (UW+1)'(next_q) + (UW+1)'(HISTORY_DEPTH) - (UW+1)'(off_d);
          rslot_d = (slot_sum >= (UW+1)'(HISTORY_DEPTH)) ?
                    SW'(slot_sum - (UW+1)'(HISTORY_DEPTH)) : SW'(slot_sum);
        end else if (sc_q == ScTab) begin
          state_d = ST_DONE;
        end else if (sc_q == ScLShift || sc_q == ScRShift) shift_d = 1'b1;
        else if (sc_q == ScLShiftUp || sc_q == ScRShiftUp) shift_d = 1'b0;
        else if (sc_q == ScCaps) caps_d = !caps_q;
        else if (sc_q[7] || sc_q >= KeyCount || key == 7'd0) begin
          state_d = ST_DONE;
        end else if (key == ChNewline) begin
          if (can_push) begin
            ctl.push = 1'b1; pd = '{KindEcho, ChNewline, 5'd0};
            handled_d = 1'b1; idx_d = '0; state_d = ST_FIN_CH;
          end else state_d = ST_DECODE;
        end else if (key == ChBackspace) begin
          if (fill_q != '0) begin
            if (can_push) begin
              ctl.push = 1'b1; pd = '{KindEcho, ChBackspace, 5'd0};
              fill_d = fill_q - 5'd1;
            end else state_d = ST_DECODE;
          end
        end else begin
          if (can_push) begin
            ctl.push = 1'b1; pd = '{KindEcho, key, 5'd0};
            lwe = 1'b1; fill_d = fill_q + 5'd1;
            handled_d = 1'b1; state_d = ST_PRE;
          end else state_d = ST_DECODE;
        end
      end
      ST_ERASE: begin
        if (fill_q == '0) begin
          if (load_q) begin
            ldn_d = (hlen_mem[rslot_q] > maxc) ? maxc : hlen_mem[rslot_q];
            idx_d = '0; state_d = ST_LOAD;
          end else state_d = ST_DONE;
        end else if (can_push) begin
          ctl.push = 1'b1; pd = '{KindEcho, ChBackspace, 5'd0};
          fill_d = fill_q - 5'd1;
        end
      end
      ST_LOAD: begin
        if (idx_q == ldn_q) begin
          fill_d = ldn_q; state_d = ST_DONE;
        end else if (can_push) begin
          ctl.push = 1'b1; pd = '{KindEcho, hist_rd_q, 5'd0};
          lwe = 1'b1; lwa = idx_q; lwd = hist_rd_q; idx_d = idx_q + 5'd1;
        end
      end
      ST_DONE: begin
        ctl.close = 1'b1;
        if (closed) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; sc_q <= '0; handled_q <= 1'b0; load_q <= 1'b0;
      shift_q <= 1'b0; caps_q <= 1'b0; prefix_q <= 1'b0;
      fill_q <= '0; idx_q <= '0; ldn_q <= '0;
      next_q <= '0; rslot_q <= '0; used_q <= '0; off_q <= '0;
      limit_q <= 6'd32;
    end else begin
      state_q <= state_d; sc_q <= sc_d; handled_q <= handled_d; load_q <= load_d;
      shift_q <= shift_d; caps_q <= caps_d; prefix_q <= prefix_d;
      fill_q <= fill_d; idx_q <= idx_d; ldn_q <= ldn_d;
      next_q <= next_d; rslot_q <= rslot_d; used_q <= used_d; off_q <= off_d;
      if (cfg_we_i) limit_q <= cfg_data_i;
    end
  end

  // line memory: one write, one registered read at the next index
  always_ff @(posedge clk_i) begin
    if (lwe) line_mem[lwa] <= lwd;
    line_rd_q <= line_mem[idx_d];
  end

  // history text and lengths
  always_ff @(posedge clk_i) begin
    if (hwe) hist_mem[{next_q, idx_q}] <= line_rd_q;
    if (hlwe) hlen_mem[next_q] <= fill_q;
    hist_rd_q <= hist_mem[{rslot_q, idx_d}];
  end

  sle_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .data_i     (pd),
    .can_push_o (can_push),
    .closed_o   (closed),
    .res_o      (res_o)
  );

endmodule

>>> hdl/sle_out_stage.sv
// Output stage: one pending result plus the output register; marks the last result
module sle_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sle_pkg::ost_ctl_t ctl_i,
  input  sle_pkg::res_t   data_i,
  output logic            can_push_o,
  output logic            closed_o,
  sle_res_if.source       res_o
);
  import sle_pkg::*;

  logic out_v_q, pnd_v_q, last_q;
  res_t out_q, pnd_q;
  logic out_free;

  assign out_free   = !out_v_q || res_o.ready;
  assign can_push_o = !pnd_v_q || out_free;
  assign closed_o   = !pnd_v_q || out_free;

  assign res_o.valid       = out_v_q;
  assign res_o.kind        = out_q.kind;
  assign res_o.char_code   = out_q.char_code;
  assign res_o.line_length = out_q.line_length;
  assign res_o.last        = last_q;

  // control: pending holds the newest result until we know whether it is final
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      pnd_v_q <= 1'b0;
    end else if (ctl_i.push) begin
      pnd_v_q <= 1'b1;
      if (pnd_v_q) out_v_q <= 1'b1;
      else if (res_o.ready) out_v_q <= 1'b0;
    end else if (ctl_i.close && pnd_v_q && out_free) begin
      out_v_q <= 1'b1;
      pnd_v_q <= 1'b0;
    end else if (res_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      pnd_q <= data_i;
      if (pnd_v_q) begin
        out_q  <= pnd_q;
        last_q <= 1'b0;
      end
    end else if (ctl_i.close && pnd_v_q && out_free) begin
      out_q  <= pnd_q;
      last_q <= 1'b1;
    end
  end

endmodule

>>> hdl/sle_chk.sv
// Port-level checker for the line editor, bound to the top level
`include "assert_macros.svh"

module sle_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [1:0] kind_i,
  input logic [6:0] char_code_i,
  input logic [4:0] line_length_i,
  input logic       last_i
);
  import sle_pkg::*;

  // stalled result holds
  `SLE_ASSERT_IMP(a_hold, res_valid_i && !res_ready_i, ##1 (res_valid_i && $stable(kind_i)))
  // end marker carries no character
  `SLE_ASSERT_IMP(a_end_char, res_valid_i && kind_i == KindEnd, char_code_i == 7'd0)
  // only the end marker carries a length
  `SLE_ASSERT_IMP(a_len, res_valid_i && kind_i != KindEnd, line_length_i == 5'd0)
  // while an item still has results to come, no new scancode is taken
  `SLE_ASSERT_IMP(a_no_overlap, res_valid_i && res_ready_i && !last_i, !in_ready_i)

endmodule

bind scancode_line_editor_with_history_unit sle_chk u_sle_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .kind_i        (res_o.kind),
  .char_code_i   (res_o.char_code),
  .line_length_i (res_o.line_length),
  .last_i        (res_o.last)
);

>>> test/sle_result_checker.sv
// Result checker: mirrors the line editor state and compares every result transfer
module sle_result_checker
  import sle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  sle_in_if          in_mon,
  sle_res_if         res_mon,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_data_i,
  output int         errors_o,
  output int         pending_o
);

  localparam int HistDepth = 16;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] ch;
    logic [4:0] len;
    logic       last;
  } editor_out_t;

  editor_out_t expected_q[$];

  // Mirrored editor state
  logic [5:0] limit_reg;
  logic       shift_on, caps_lock, ext_pending;
  logic [6:0] line_buf [LineCap];
  int         fill;
  logic [6:0] hist_text [HistDepth][LineCap];
  int         hist_cnt [HistDepth];
  int         hist_next, hist_used, recall_pos;

  function automatic int char_room();
    int l;
    l = limit_reg;
    if (l < 2) l = 2;
    if (l > LineCap) l = LineCap;
    return l - 1;
  endfunction

  function automatic void push_out(logic [1:0] k, logic [6:0] c, int n);
    editor_out_t r;
    r.kind = k;
    r.ch   = c;
    r.len  = n[4:0];
    r.last = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void close_line();
    int n;
    n = (fill > LineCap - 1) ? LineCap - 1 : fill;
    for (int i = 0; i < n; i++) push_out(KindLine, line_buf[i], 0);
    push_out(KindEnd, 7'd0, n);
    if (n > 0) begin
      for (int i = 0; i < n; i++) hist_text[hist_next][i] = line_buf[i];
      hist_cnt[hist_next] = n;
      hist_next = (hist_next + 1) % HistDepth;
      if (hist_used < HistDepth) hist_used++;
    end
    shift_on = 0;
    caps_lock = 0;
    ext_pending = 0;
    fill = 0;
    recall_pos = 0;
  endfunction

  function automatic void rub_out_line();
    while (fill > 0) begin
      fill--;
      push_out(KindEcho, ChBackspace, 0);
    end
  endfunction

  function automatic void recall_line();
    int slot, n;
    slot = (hist_next + HistDepth - recall_pos) % HistDepth;
    n = hist_cnt[slot];
    if (n > char_room()) n = char_room();
    for (int j = 0; j < n; j++) begin
      line_buf[j] = hist_text[slot][j];
      push_out(KindEcho, line_buf[j], 0);
    end
    fill = n;
  endfunction

  function automatic void edit_key(logic [7:0] sc);
    logic [6:0] c;
    if (sc == ScPrefix) begin
      ext_pending = 1;
      return;
    end
    if (ext_pending) begin
      ext_pending = 0;
      if (sc == ScUp) begin
        if (recall_pos + 1 > hist_used) return;
        recall_pos++;
        rub_out_line();
        recall_line();
      end else if (sc == ScDown) begin
        if (recall_pos == 0) return;
        recall_pos--;
        rub_out_line();
        if (recall_pos != 0) recall_line();
      end
      return;
    end
    if (sc == ScTab) return;
    if (sc == ScLShift || sc == ScRShift) begin
      shift_on = 1;
      return;
    end
    if (sc == ScLShiftUp || sc == ScRShiftUp) begin
      shift_on = 0;
      return;
    end
    if (sc == ScCaps) begin
      caps_lock = ~caps_lock;
      return;
    end
    if (sc[7] || sc >= KeyCount) return;
    c = (shift_on ^ caps_lock) ? ShiftKeys[sc] : PlainKeys[sc];
    if (c == 7'd0) return;
    if (c == ChNewline) begin
      push_out(KindEcho, ChNewline, 0);
      close_line();
      return;
    end
    if (c == ChBackspace) begin
      if (fill > 0) begin
        fill--;
        push_out(KindEcho, ChBackspace, 0);
      end
      return;
    end
    if (fill < LineCap) line_buf[fill] = c;
    fill++;
    push_out(KindEcho, c, 0);
    if (fill >= char_room()) close_line();
  endfunction

  // Expected results of one accepted scancode
  function automatic void predict_scancode(logic [7:0] sc);
    int base;
    base = expected_q.size();
    if (fill >= char_room()) close_line();
    edit_key(sc);
    if (expected_q.size() > base) expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    editor_out_t e;
    if (!rst_ni) begin
      errors_o = 0;
      limit_reg = 6'd32;
      shift_on = 0;
      caps_lock = 0;
      ext_pending = 0;
      fill = 0;
      hist_next = 0;
      hist_used = 0;
      recall_pos = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) limit_reg = cfg_data_i;
      if (in_mon.valid && in_mon.ready) predict_scancode(in_mon.scancode);
      // Compare each result transfer with the oldest expectation
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result kind=%0d char=%0d len=%0d last=%0d", $time,
                   res_mon.kind, res_mon.char_code, res_mon.line_length, res_mon.last);
        end else begin
          e = expected_q.pop_front();
          if (res_mon.kind !== e.kind || res_mon.char_code !== e.ch ||
              res_mon.line_length !== e.len || res_mon.last !== e.last) begin
            errors_o++;
            $display("%0t: mismatch expected kind=%0d char=%0d len=%0d last=%0d", $time,
                     e.kind, e.ch, e.len, e.last);
            $display("%0t:          actual   kind=%0d char=%0d len=%0d last=%0d", $time,
                     res_mon.kind, res_mon.char_code, res_mon.line_length, res_mon.last);
          end
        end
      end
    end
  end

endmodule

>>> test/scancode_line_editor_with_history_unit_tb.sv
// Testbench top: clock, reset, scancode stimulus, config phases and verdict
module scancode_line_editor_with_history_unit_tb;
  import sle_pkg::*;

  localparam logic [7:0] ScBackspace = 8'h0E;
  localparam logic [7:0] ScEnter     = 8'h1C;
  localparam logic [7:0] ScA         = 8'h1E;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic [5:0] cfg_data = 6'd32;
  int         errors, pending;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         sent = 0;

  sle_in_if  in_ch ();
  sle_res_if res_ch ();

  scancode_line_editor_with_history_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  sle_result_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_ch),
    .res_mon    (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.scancode = 8'h00;
    res_ch.ready = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk_i) res_ch.ready <= ($urandom_range(99) >= stall_pct);

  // One scancode transfer, with a random gap ahead of it
  task automatic send_code(logic [7:0] sc);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.scancode <= sc;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  // Let everything drain, then write the line limit
  task automatic set_limit(logic [5:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic random_code();
    int r;
    r = $urandom_range(99);
    if (r < 48) send_code(8'($urandom_range(8'h02, 8'h35)));
    else if (r < 55) send_code(ScEnter);
    else if (r < 62) send_code(ScBackspace);
    else if (r < 72) begin
      send_code(ScPrefix);
      send_code($urandom_range(2) != 0 ? ScUp : ScDown);
    end else if (r < 78) send_code($urandom_range(1) ? ScLShift : ScLShiftUp);
    else if (r < 81) send_code($urandom_range(1) ? ScRShift : ScRShiftUp);
    else if (r < 83) send_code(ScCaps);
    else send_code(8'($urandom_range(255)));
  endtask

  initial begin
    logic [5:0] limits [4];
    int         idle_set [4], stall_set [4];
    limits = '{6'd0, 6'd63, 6'd5, 6'd32};
    idle_set = '{0, 48, 0, 11};
    stall_set = '{0, 0, 48, 11};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: typing, modifiers, empty keys, recall at both ends
    send_code(ScBackspace);
    send_code(ScTab);
    send_code(8'h3B);
    send_code(8'hFF);
    send_code(8'h9E);
    send_code(8'h00);
    send_code(ScLShift);
    send_code(ScA);
    send_code(ScLShiftUp);
    send_code(ScCaps);
    send_code(8'h02);
    send_code(ScA);
    send_code(ScEnter);
    send_code(8'h39);
    send_code(ScBackspace);
    send_code(ScPrefix);
    send_code(ScPrefix);
    send_code(ScUp);
    send_code(ScPrefix);
    send_code(ScUp);
    send_code(ScPrefix);
    send_code(ScDown);
    send_code(ScPrefix);
    send_code(ScDown);
    send_code(ScPrefix);
    send_code(ScEnter);
    send_code(ScPrefix);
    send_code(ScUp);

    // Shrink the limit under a recalled line: finished on the next code
    set_limit(6'd2);
    send_code(ScTab);
    send_code(ScA);

    // Random phases across limit settings and idling patterns
    for (int p = 0; p < 4; p++) begin
      set_limit(limits[p]);
      send_idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      for (int i = 0; i < 33; i++) random_code();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("scancode_line_editor_with_history_unit verification clean");
    else $display("scancode_line_editor_with_history_unit verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #40000000;
    $display("scancode_line_editor_with_history_unit verification failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/sle_pkg.sv
hdl/sle_in_if.sv
hdl/sle_res_if.sv
hdl/sle_out_stage.sv
hdl/scancode_line_editor_with_history_unit.sv
hdl/sle_chk.sv
test/sle_result_checker.sv
test/scancode_line_editor_with_history_unit_tb.sv
